[design/glyph_atlas_lru_cache_core_assert.svh]
// Assertion macros shared by the glyph atlas cache RTL.
`ifndef GLYPH_ATLAS_LRU_CACHE_CORE_ASSERT_SVH
`define GLYPH_ATLAS_LRU_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define GALC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph atlas cache check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define GALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph atlas cache check failed");

`endif

[design/galc_pkg.sv]
// Shared types and constants of the glyph atlas cache.
package galc_pkg;

  localparam int unsigned SLOTS_DEFAULT = 256;
  localparam int unsigned CODE_W        = 16;
  localparam int unsigned STAMP_W       = 64;
  localparam int unsigned ROW_LOG2_W    = 3;
  localparam int unsigned OUT_INDEX_W   = 8;
  localparam int unsigned OUT_RC_W      = 4;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [ROW_LOG2_W-1:0] ROW_LOG2_RESET = 3'd4;
  localparam logic [ROW_LOG2_W-1:0] ROW_LOG2_MAX   = 3'd4;

  // Register byte address of row_length_log2
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH_LOG2 = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINISH
  } galc_state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic commit;
    logic load_out;
  } galc_cmd_t;

  typedef struct packed {
    logic present;
    logic filled_zero;
    logic scan_last;
    logic out_blocked;
  } galc_stat_t;

endpackage

[design/glyph_atlas_lru_cache_core.sv]
// Top level of the glyph atlas cache: config register, sequencer, datapath, checks.
//
// Fully associative glyph atlas cache with least recently used replacement.
// Each item is looked up by a linear scan of the tag and stamp stores, one
// resident slot per cycle through their single read port. An item with a
// present glyph passes from idle through the scan of all resident slots (at
// most SLOTS), a drain state and commit to finish, which loads its result.
// While the atlas is empty the scan and drain are skipped. An absent glyph
// goes straight from idle to finish. Finish waits while the result register
// stays full. The scan finds the first matching tag and the slot with the
// smallest stamp (lowest slot on ties) in the same pass. A finished result
// waits in an output register, and a new item is accepted as soon as the
// sequencer is back in idle. The stores need no clearing after reset: only
// slots below the fill count are ever read. row_length_log2 sits at byte
// address 0 of the register port; values above 4 act as 4.
`include "glyph_atlas_lru_cache_core_assert.svh"

module glyph_atlas_lru_cache_core import galc_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_start_of_text,
  input  logic [CODE_W-1:0]      in_glyph_code,
  input  logic                   in_glyph_present,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_placed,
  output logic                   out_hit,
  output logic [OUT_INDEX_W-1:0] out_slot_index,
  output logic [OUT_RC_W-1:0]    out_slot_row,
  output logic [OUT_RC_W-1:0]    out_slot_column,
  output logic                   out_needs_upload,
  output logic                   out_evicted,
  output logic [CODE_W-1:0]      out_evicted_code,
  // Register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [ROW_LOG2_W-1:0] row_log2_r, row_log2_nxt;
  logic                  cfg_wr;
  galc_cmd_t             cmd;
  galc_stat_t            stat;
  logic                  absent_clear;

  // Register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == REG_ROW_LENGTH_LOG2);
  assign row_log2_nxt = cfg_wr ? cfg_pwdata[ROW_LOG2_W-1:0] : row_log2_r;
  assign cfg_prdata = (cfg_paddr == REG_ROW_LENGTH_LOG2) ? CFG_DATA_W'(row_log2_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_log2_r <= ROW_LOG2_RESET;
    end else begin
      row_log2_r <= row_log2_nxt;
    end
  end

  galc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  galc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .row_length_log2  (row_log2_r),
    .in_start_of_text (in_start_of_text),
    .in_glyph_code    (in_glyph_code),
    .in_glyph_present (in_glyph_present),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_placed       (out_placed),
    .out_hit          (out_hit),
    .out_slot_index   (out_slot_index),
    .out_slot_row     (out_slot_row),
    .out_slot_column  (out_slot_column),
    .out_needs_upload (out_needs_upload),
    .out_evicted      (out_evicted),
    .out_evicted_code (out_evicted_code)
  );

  // Fields that an absent-glyph result leaves at zero
  assign absent_clear = !out_hit && !out_needs_upload && !out_evicted
                        && (out_slot_index == '0) && (out_evicted_code == '0);

  // One item at a time: taking an item closes the input side
  `GALC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // An eviction is always an upload and never a hit
  `GALC_ASSERT_NOW(a_evict_is_miss, out_valid && out_evicted, out_needs_upload && !out_hit)
  // A hit never asks for an upload
  `GALC_ASSERT_NOW(a_hit_no_upload, out_valid && out_hit, !out_needs_upload && out_placed)
  // An absent glyph gives an all-zero result
  `GALC_ASSERT_NOW(a_absent_zero, out_valid && !out_placed, absent_clear)

endmodule

[design/galc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module galc_ram import galc_pkg::*; #(
  parameter int unsigned WIDTH = CODE_W,
  parameter int unsigned DEPTH = SLOTS_DEFAULT,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/galc_ctrl.sv]
// Sequencer of the glyph atlas cache: accept, scan, decide, deliver.
module galc_ctrl import galc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  galc_stat_t stat,
  output galc_cmd_t  cmd
);

  galc_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (!stat.present) begin
            state_nxt = ST_FINISH;
          end else if (stat.filled_zero) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!stat.out_blocked) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN:   cmd.scan_rd  = 1'b1;
      ST_DRAIN:  cmd          = '0;
      ST_COMMIT: cmd.commit   = 1'b1;
      ST_FINISH: cmd.load_out = !stat.out_blocked;
      default:   cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/galc_dp.sv]
// Datapath of the glyph atlas cache: tag and stamp stores, scan, result register.
module galc_dp import galc_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  galc_cmd_t              cmd,
  output galc_stat_t             stat,
  input  logic [ROW_LOG2_W-1:0]  row_length_log2,
  input  logic                   in_start_of_text,
  input  logic [CODE_W-1:0]      in_glyph_code,
  input  logic                   in_glyph_present,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_placed,
  output logic                   out_hit,
  output logic [OUT_INDEX_W-1:0] out_slot_index,
  output logic [OUT_RC_W-1:0]    out_slot_row,
  output logic [OUT_RC_W-1:0]    out_slot_column,
  output logic                   out_needs_upload,
  output logic                   out_evicted,
  output logic [CODE_W-1:0]      out_evicted_code
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Control registers
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;
  logic [CW-1:0]      filled_r, filled_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [SW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [SW-1:0]      rd_slot_r, rd_slot_nxt;
  logic               found_r, found_nxt;
  logic [SW-1:0]      hit_slot_r, hit_slot_nxt;
  logic [STAMP_W-1:0] min_stamp_r, min_stamp_nxt;
  logic [SW-1:0]      min_slot_r, min_slot_nxt;
  logic [CODE_W-1:0]  min_tag_r, min_tag_nxt;

  logic                   pend_placed_r, pend_placed_nxt;
  logic                   pend_hit_r, pend_hit_nxt;
  logic [OUT_INDEX_W-1:0] pend_index_r, pend_index_nxt;
  logic [OUT_RC_W-1:0]    pend_row_r, pend_row_nxt;
  logic [OUT_RC_W-1:0]    pend_col_r, pend_col_nxt;
  logic                   pend_upload_r, pend_upload_nxt;
  logic                   pend_evicted_r, pend_evicted_nxt;
  logic [CODE_W-1:0]      pend_ev_code_r, pend_ev_code_nxt;

  logic                   o_placed_r, o_hit_r, o_upload_r, o_evicted_r;
  logic [OUT_INDEX_W-1:0] o_index_r;
  logic [OUT_RC_W-1:0]    o_row_r, o_col_r;
  logic [CODE_W-1:0]      o_ev_code_r;

  // Store ports
  logic [CODE_W-1:0]     tag_rdata;
  logic [STAMP_W-1:0]    stamp_rdata;
  logic [SW-1:0]         wr_slot;
  logic                  room;
  logic [ROW_LOG2_W-1:0] shift;
  logic [31:0]           slot_ext;
  logic [31:0]           cap_sq;

  galc_ram #(.WIDTH(CODE_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wr_slot),
    .wdata (code_r),
    .re    (cmd.scan_rd),
    .raddr (scan_idx_r),
    .rdata (tag_rdata)
  );

  galc_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wr_slot),
    .wdata (use_clock_r),
    .re    (cmd.scan_rd),
    .raddr (scan_idx_r),
    .rdata (stamp_rdata)
  );

  // Saturate the row length and derive the fill limit
  assign shift  = (row_length_log2 > ROW_LOG2_MAX) ? ROW_LOG2_MAX : row_length_log2;
  assign cap_sq = 32'd1 << {shift, 1'b0};
  assign room   = (32'(filled_r) < 32'(SLOTS)) && (32'(filled_r) < cap_sq);

  // Pick the slot written on commit: hit slot, next free slot, or LRU victim
  always_comb begin
    priority if (found_r) begin
      wr_slot = hit_slot_r;
    end else if (room) begin
      wr_slot = SW'(filled_r);
    end else begin
      wr_slot = min_slot_r;
    end
  end

  assign slot_ext = 32'(wr_slot);

  // Status to the sequencer
  assign stat.present     = in_glyph_present;
  assign stat.filled_zero = (filled_r == '0);
  assign stat.scan_last   = (CW'(scan_idx_r) == filled_r - CW'(1));
  assign stat.out_blocked = out_valid_r && !out_ready;

  // Next-state logic of the datapath
  always_comb begin
    use_clock_nxt    = use_clock_r;
    filled_nxt       = filled_r;
    code_nxt         = code_r;
    scan_idx_nxt     = scan_idx_r;
    rd_vld_nxt       = cmd.scan_rd;
    rd_slot_nxt      = scan_idx_r;
    found_nxt        = found_r;
    hit_slot_nxt     = hit_slot_r;
    min_stamp_nxt    = min_stamp_r;
    min_slot_nxt     = min_slot_r;
    min_tag_nxt      = min_tag_r;
    pend_placed_nxt  = pend_placed_r;
    pend_hit_nxt     = pend_hit_r;
    pend_index_nxt   = pend_index_r;
    pend_row_nxt     = pend_row_r;
    pend_col_nxt     = pend_col_r;
    pend_upload_nxt  = pend_upload_r;
    pend_evicted_nxt = pend_evicted_r;
    pend_ev_code_nxt = pend_ev_code_r;
    out_valid_nxt    = out_valid_r;

    // Take the item: advance the use clock on start of text, clear the search and the result
    if (cmd.accept) begin
      use_clock_nxt    = use_clock_r + STAMP_W'(in_start_of_text);
      code_nxt         = in_glyph_code;
      scan_idx_nxt     = '0;
      found_nxt        = 1'b0;
      pend_placed_nxt  = 1'b0;
      pend_hit_nxt     = 1'b0;
      pend_index_nxt   = '0;
      pend_row_nxt     = '0;
      pend_col_nxt     = '0;
      pend_upload_nxt  = 1'b0;
      pend_evicted_nxt = 1'b0;
      pend_ev_code_nxt = '0;
    end

    // Advance the read address through the resident slots
    if (cmd.scan_rd) begin
      scan_idx_nxt = scan_idx_r + SW'(1);
    end

    // Compare one returned entry: first tag match, smallest stamp
    if (rd_vld_r) begin
      if (!found_r && (tag_rdata == code_r)) begin
        found_nxt    = 1'b1;
        hit_slot_nxt = rd_slot_r;
      end
      if ((rd_slot_r == '0) || (stamp_rdata < min_stamp_r)) begin
        min_stamp_nxt = stamp_rdata;
        min_slot_nxt  = rd_slot_r;
        min_tag_nxt   = tag_rdata;
      end
    end

    // Decide and build the result
    if (cmd.commit) begin
      if (!found_r && room) begin
        filled_nxt = filled_r + CW'(1);
      end
      pend_placed_nxt  = 1'b1;
      pend_hit_nxt     = found_r;
      pend_index_nxt   = OUT_INDEX_W'(slot_ext);
      pend_row_nxt     = OUT_RC_W'(slot_ext >> shift);
      pend_col_nxt     = OUT_RC_W'(slot_ext & ((32'd1 << shift) - 32'd1));
      pend_upload_nxt  = !found_r;
      pend_evicted_nxt = !found_r && !room;
      pend_ev_code_nxt = (!found_r && !room) ? min_tag_r : '0;
    end

    // Hold or drop the result register
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_clock_r <= '0;
      filled_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      use_clock_r <= use_clock_nxt;
      filled_r    <= filled_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    code_r         <= code_nxt;
    scan_idx_r     <= scan_idx_nxt;
    rd_slot_r      <= rd_slot_nxt;
    found_r        <= found_nxt;
    hit_slot_r     <= hit_slot_nxt;
    min_stamp_r    <= min_stamp_nxt;
    min_slot_r     <= min_slot_nxt;
    min_tag_r      <= min_tag_nxt;
    pend_placed_r  <= pend_placed_nxt;
    pend_hit_r     <= pend_hit_nxt;
    pend_index_r   <= pend_index_nxt;
    pend_row_r     <= pend_row_nxt;
    pend_col_r     <= pend_col_nxt;
    pend_upload_r  <= pend_upload_nxt;
    pend_evicted_r <= pend_evicted_nxt;
    pend_ev_code_r <= pend_ev_code_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_placed_r  <= pend_placed_r;
      o_hit_r     <= pend_hit_r;
      o_index_r   <= pend_index_r;
      o_row_r     <= pend_row_r;
      o_col_r     <= pend_col_r;
      o_upload_r  <= pend_upload_r;
      o_evicted_r <= pend_evicted_r;
      o_ev_code_r <= pend_ev_code_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_placed       = o_placed_r;
  assign out_hit          = o_hit_r;
  assign out_slot_index   = o_index_r;
  assign out_slot_row     = o_row_r;
  assign out_slot_column  = o_col_r;
  assign out_needs_upload = o_upload_r;
  assign out_evicted      = o_evicted_r;
  assign out_evicted_code = o_ev_code_r;

endmodule
